// ===== design/xidp_pkg.sv =====
// Shared types, codes and protocol defaults for the XID information field parser.
package xidp_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK         = 2'd0;
    localparam status_t STATUS_SHORT      = 2'd1;
    localparam status_t STATUS_BAD_FORMAT = 2'd2;

    localparam logic [7:0] FORMAT_ID = 8'h82;

    // Parameter identifiers inside a group.
    localparam logic [7:0] PI_CLASSES    = 8'd2;
    localparam logic [7:0] PI_HDLC_FUNCS = 8'd3;
    localparam logic [7:0] PI_IFIELD_RX  = 8'd6;
    localparam logic [7:0] PI_WINDOW_RX  = 8'd8;
    localparam logic [7:0] PI_T1         = 8'd9;
    localparam logic [7:0] PI_RETRIES    = 8'd10;
    localparam logic [7:0] PI_RESP_DELAY = 8'd11;

    localparam logic [12:0] DEF_INFO_LEN_MAX = 13'd256;
    localparam logic [7:0]  DEF_RX_WINDOW    = 8'd4;
    localparam logic [15:0] DEF_T1_MSEC      = 16'd10000;
    localparam logic [7:0]  DEF_RETRIES      = 8'd10;
    localparam logic [15:0] DEF_RESP_DELAY   = 16'd3000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } in_beat_t;

    typedef struct packed {
        logic        fdx_offered;
        logic        srej_ok;
        logic        rej_ok;
        logic        modulo128;
        logic [12:0] info_len_max;
        logic [7:0]  rx_window;
        logic [15:0] t1_msec;
        logic [7:0]  retries;
        logic [15:0] t2_msec;
    } params_t;

    typedef struct packed {
        status_t     status;
        logic        fdx_offered;
        logic        srej_ok;
        logic        rej_ok;
        logic        modulo128;
        logic [12:0] info_len_max;
        logic [7:0]  rx_window;
        logic [15:0] t1_msec;
        logic [7:0]  retries;
        logic [15:0] t2_msec;
    } out_beat_t;

    function automatic params_t default_params();
        params_t p;
        p.fdx_offered  = 1'b0;
        p.srej_ok      = 1'b0;
        p.rej_ok       = 1'b0;
        p.modulo128    = 1'b0;
        p.info_len_max = DEF_INFO_LEN_MAX;
        p.rx_window    = DEF_RX_WINDOW;
        p.t1_msec      = DEF_T1_MSEC;
        p.retries      = DEF_RETRIES;
        p.t2_msec      = DEF_RESP_DELAY;
        return p;
    endfunction

endpackage

// ===== design/xidp_field_walker.sv =====
// Byte-by-byte walker over the XID header and PI/PL/PV triples.
module xidp_field_walker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                beat_fire,
    input  xidp_pkg::in_beat_t  beat,
    output xidp_pkg::out_beat_t result
);

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_PI     = 5'b00010,
        PH_PL     = 5'b00100,
        PH_VALUE  = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    logic [15:0]       pos_reg,   pos_next;
    logic              fmt_reg,   fmt_next;
    logic [7:0]        glh_reg,   glh_next;
    logic [15:0]       gend_reg,  gend_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        id_reg,    id_next;
    logic [7:0]        len_reg,   len_next;
    logic [7:0]        seen_reg,  seen_next;
    logic [7:0]        b0_reg,    b0_next;
    logic [7:0]        b1_reg,    b1_next;
    xidp_pkg::params_t par_reg,   par_next;

    logic        apply_en;
    logic [16:0] pv_end;
    logic [7:0]  b;

    function automatic xidp_pkg::params_t apply_triple(
        input xidp_pkg::params_t p_in,
        input logic [7:0]        id,
        input logic [7:0]        pl,
        input logic [7:0]        v0,
        input logic [7:0]        v1
    );
        xidp_pkg::params_t p;
        logic [15:0]       word;
        p    = p_in;
        word = {v0, v1};
        case (id)
            xidp_pkg::PI_CLASSES: begin
                if (pl != 8'd0) p.fdx_offered = v0[1];
            end
            xidp_pkg::PI_HDLC_FUNCS: begin
                if (pl != 8'd0) begin
                    p.rej_ok  = v0[1];
                    p.srej_ok = v0[2];
                end
                if (pl >= 8'd2) p.modulo128 = v1[5];
            end
            xidp_pkg::PI_IFIELD_RX: begin
                if (pl == 8'd2) begin
                    p.info_len_max = (word == 16'd0) ? xidp_pkg::DEF_INFO_LEN_MAX
                                                     : word[15:3];
                end
            end
            xidp_pkg::PI_WINDOW_RX: begin
                if (pl == 8'd1) p.rx_window = v0;
            end
            xidp_pkg::PI_T1: begin
                if (pl == 8'd2) p.t1_msec = word;
            end
            xidp_pkg::PI_RETRIES: begin
                if (pl == 8'd1) p.retries = v0;
            end
            xidp_pkg::PI_RESP_DELAY: begin
                if (pl == 8'd2) p.t2_msec = word;
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    assign b      = beat.data_byte;
    assign pv_end = {1'b0, pos_reg} + 17'd1 + {9'd0, b};

    always_comb begin
        fmt_next   = fmt_reg;
        glh_next   = glh_reg;
        gend_next  = gend_reg;
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        apply_en   = 1'b0;
        pos_next   = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;

        if (pos_reg == 16'd0) begin
            fmt_next = (b == xidp_pkg::FORMAT_ID);
        end else if (pos_reg == 16'd2) begin
            glh_next = b;
        end else if (pos_reg == 16'd3) begin
            gend_next  = 16'd4 + {glh_reg, b};
            phase_next = PH_PI;
        end else if (pos_reg >= 16'd4 && pos_reg < gend_reg && phase_reg != PH_DONE) begin
            case (phase_reg)
                PH_PI: begin
                    id_next    = b;
                    phase_next = PH_PL;
                end
                PH_PL: begin
                    len_next  = b;
                    seen_next = 8'd0;
                    b0_next   = 8'd0;
                    b1_next   = 8'd0;
                    if (pv_end > {1'b0, gend_reg}) begin
                        phase_next = PH_DONE;
                    end else if (b == 8'd0) begin
                        apply_en   = 1'b1;
                        phase_next = PH_PI;
                    end else begin
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (seen_reg == 8'd0) b0_next = b;
                    else if (seen_reg == 8'd1) b1_next = b;
                    seen_next = seen_reg + 8'd1;
                    if (seen_next >= len_reg) begin
                        apply_en   = 1'b1;
                        phase_next = PH_PI;
                    end
                end
                default: begin
                end
            endcase
        end

        par_next = apply_en ? apply_triple(par_reg, id_reg, len_next, b0_next, b1_next)
                            : par_reg;
    end

    // Result for a last beat: parameters after this beat's update.
    always_comb begin
        xidp_pkg::params_t p;
        if (pos_reg < 16'd3) begin
            result.status = xidp_pkg::STATUS_SHORT;
        end else if (!fmt_next) begin
            result.status = xidp_pkg::STATUS_BAD_FORMAT;
        end else begin
            result.status = xidp_pkg::STATUS_OK;
        end
        p = (result.status == xidp_pkg::STATUS_OK) ? par_next : xidp_pkg::default_params();
        result.fdx_offered  = p.fdx_offered;
        result.srej_ok      = p.srej_ok;
        result.rej_ok       = p.rej_ok;
        result.modulo128    = p.modulo128;
        result.info_len_max = p.info_len_max;
        result.rx_window    = p.rx_window;
        result.t1_msec      = p.t1_msec;
        result.retries      = p.retries;
        result.t2_msec      = p.t2_msec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_fire && beat.frame_last)) begin
            pos_reg   <= 16'd0;
            fmt_reg   <= 1'b0;
            glh_reg   <= 8'd0;
            gend_reg  <= 16'd0;
            phase_reg <= PH_HEADER;
            id_reg    <= 8'd0;
            len_reg   <= 8'd0;
            seen_reg  <= 8'd0;
            b0_reg    <= 8'd0;
            b1_reg    <= 8'd0;
            par_reg   <= xidp_pkg::default_params();
        end else if (beat_fire) begin
            pos_reg   <= pos_next;
            fmt_reg   <= fmt_next;
            glh_reg   <= glh_next;
            gend_reg  <= gend_next;
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            b0_reg    <= b0_next;
            b1_reg    <= b1_next;
            par_reg   <= par_next;
        end
    end

endmodule

// ===== design/xidp_result_reg.sv =====
// Output register holding one result beat until the receiver takes it.
module xidp_result_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  xidp_pkg::out_beat_t load_beat,
    output logic                m_valid,
    input  logic                m_ready,
    output xidp_pkg::out_beat_t m_data
);

    logic                valid_reg, valid_next;
    xidp_pkg::out_beat_t data_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= load_beat;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== design/xid_info_field_parser_top.sv =====
// Top level of the XID information field parser: input register, walker and result register.
// The block decodes the information field of an XID frame, one byte per input beat.
// The input channel (s_valid, s_ready, s_data) carries a data byte and a flag that
// marks the last byte of the field. Only the beat carrying that flag produces a
// result beat on the output channel (m_valid, m_ready, m_data): a status code and
// the peer's link parameters, which fall back to protocol defaults on an error.
// Each accepted beat is captured in an input register; from there the walker updates
// its header and triple state, and a last beat loads the result register, which
// drives m_valid. Throughput is one byte per cycle while no last byte waits in the
// input register for a pending result to be taken.
// The input register frees itself while a result still waits in the result
// register, so ordinary bytes keep flowing when the receiver stalls; only a second
// last byte waits in the input register until the pending result is taken.
// Synchronous active-low reset empties both registers and returns the walker to
// the start of a field with default parameters. After every result the walker
// also returns to that state, ready for the next field.
module xid_info_field_parser_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  xidp_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output xidp_pkg::out_beat_t m_data
);

    logic                in_valid_reg, in_valid_next;
    xidp_pkg::in_beat_t  in_beat_reg;
    logic                advance;
    xidp_pkg::out_beat_t walk_result;

    // A held beat moves on unless it is a last byte facing a full result register.
    assign advance = in_valid_reg && (!in_beat_reg.frame_last || !m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
    end

    xidp_field_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_fire (advance),
        .beat      (in_beat_reg),
        .result    (walk_result)
    );

    xidp_result_reg u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && in_beat_reg.frame_last),
        .load_beat (walk_result),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
